>>> hw/rtl/key_frequency_count_table_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the key frequency count table
// Concurrent assertion wrappers clocked on clk, with and without reset masking.
// ----------------------------------------------------------------------------
`ifndef KEY_FREQUENCY_COUNT_TABLE_ASSERT_SVH
`define KEY_FREQUENCY_COUNT_TABLE_ASSERT_SVH

// Checked only while the block is out of reset.
`define KFCT_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Checked at every clock edge, reset included.
`define KFCT_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

>>> hw/rtl/kfct_pkg.sv
// ----------------------------------------------------------------------------
// kfct_pkg
// Sizes, types and command codes shared by the count table and its store.
// ----------------------------------------------------------------------------
package kfct_pkg;

	localparam int ENTRIES    = 256;
	localparam int COUNT_BITS = 16;

	localparam int KEY_W   = 32;
	localparam int OCC_W   = 16;
	localparam int PROBE_W = 9;
	localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int USED_W  = $clog2(ENTRIES + 1);

	// Widths used when reported values are clamped to the output fields.
	localparam int OCC_CMP_W   = (COUNT_BITS > OCC_W) ? COUNT_BITS : OCC_W;
	localparam int PROBE_CMP_W = (USED_W > PROBE_W) ? USED_W : PROBE_W;

	localparam int OUT_DATA_W = 32;
	localparam int OUT_PAD_W  = OUT_DATA_W - OCC_W - PROBE_W;
	localparam int OUT_USER_W = 2;

	typedef enum logic {
		CMD_INSERT = 1'b0,
		CMD_LOOKUP = 1'b1
	} cmd_t;

	typedef struct packed {
		logic [COUNT_BITS-1:0] cnt;
		logic [KEY_W-1:0]      key;
	} entry_t;

	typedef struct packed {
		logic             we;
		logic [IDX_W-1:0] addr;
		entry_t           data;
	} wr_req_t;

	typedef struct packed {
		logic             en;
		logic [IDX_W-1:0] addr;
	} rd_req_t;

endpackage

>>> hw/rtl/kfct_store.sv
// ----------------------------------------------------------------------------
// kfct_store
// Key and count memory: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module kfct_store (
	input  logic              clk,
	input  kfct_pkg::wr_req_t wr,
	input  kfct_pkg::rd_req_t rd,
	output kfct_pkg::entry_t  rd_data
);

	kfct_pkg::entry_t mem [kfct_pkg::ENTRIES];

	always_ff @(posedge clk) begin
		if (wr.we) begin
			mem[wr.addr] <= wr.data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd.en) begin
			rd_data <= mem[rd.addr];
		end
	end

endmodule

>>> hw/rtl/key_frequency_count_table.sv
// ----------------------------------------------------------------------------
// key_frequency_count_table
// Table of distinct keys in arrival order with saturating occurrence counts,
// searched linearly for every insert or lookup request.
// ----------------------------------------------------------------------------
//
// Channel   Dir  tdata (low bit up)                        tuser (low bit up)
// s_*       in   key[31:0]                                 cmd
// m_*       out  occurrences[15:0], probes[24:16], zeros   found, table_full
//
// A request is taken in a transfer cycle; the search then compares entries
// in order (hit position plus one on a hit, entries_used on a miss) and
// ends in a closing cycle; the next request is taken in the cycle after
// that. The search time is set by the single read port of the key memory,
// which is walked one entry per cycle. Reset clears the fill count but not
// the key memory, so no clearing pass is needed. A result waiting in the
// output register does not block the next request, but a finished search
// holds in its closing cycle while the previous result has still not been
// taken.
module key_frequency_count_table (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // key[31:0]
	input  logic        s_tuser,   // cmd
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // occurrences[15:0], probes[24:16], zero pad
	output logic [1:0]  m_tuser    // found, table_full
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FINISH
	} state_t;

	localparam logic [kfct_pkg::COUNT_BITS-1:0] COUNT_MAX = '1;

	state_t                           state_q;
	kfct_pkg::cmd_t                   cmd_q;
	logic [kfct_pkg::KEY_W-1:0]       key_q;
	logic [kfct_pkg::USED_W-1:0]      used_q;
	logic [kfct_pkg::USED_W-1:0]      addr_q;
	logic [kfct_pkg::IDX_W-1:0]       pos_s1;
	logic                             hit_q;
	logic [kfct_pkg::IDX_W-1:0]       hit_pos_q;
	logic [kfct_pkg::COUNT_BITS-1:0]  hit_cnt_q;

	kfct_pkg::wr_req_t wr;
	kfct_pkg::rd_req_t rd;
	kfct_pkg::entry_t  rd_data;

	logic s_xfer;
	logic out_free;
	logic match;
	logic last_entry;
	logic is_insert;
	logic can_append;
	logic hit_inc;
	logic do_append;
	logic full_drop;

	logic [kfct_pkg::COUNT_BITS-1:0]  new_cnt;
	logic [kfct_pkg::COUNT_BITS-1:0]  occ_raw;
	logic [kfct_pkg::OCC_CMP_W-1:0]   occ_ext;
	logic [kfct_pkg::OCC_W-1:0]       occ_out;
	logic [kfct_pkg::USED_W-1:0]      probes_raw;
	logic [kfct_pkg::PROBE_CMP_W-1:0] probes_ext;
	logic [kfct_pkg::PROBE_W-1:0]     probes_out;

	kfct_store u_store (
		.clk     (clk),
		.wr      (wr),
		.rd      (rd),
		.rd_data (rd_data)
	);

	assign s_tready = (state_q == ST_IDLE);
	assign s_xfer   = s_tvalid && s_tready;
	assign out_free = !m_tvalid || m_tready;

	// Reads are issued back to back; the data for entry pos_s1 arrives in the
	// cycle after its address, and entry 0 is read in the transfer cycle.
	always_comb begin
		rd.en   = 1'b0;
		rd.addr = '0;
		unique case (state_q)
			ST_IDLE: begin
				rd.en = s_xfer && (used_q != '0);
			end
			ST_SCAN: begin
				rd.en   = (addr_q < used_q);
				rd.addr = addr_q[kfct_pkg::IDX_W-1:0];
			end
			default: begin
				rd.en = 1'b0;
			end
		endcase
	end

	assign match      = (rd_data.key == key_q);
	assign last_entry = ((kfct_pkg::USED_W'(pos_s1) + 1'b1) == used_q);

	// Outcome of the request, valid in the closing state.
	assign is_insert  = (cmd_q == kfct_pkg::CMD_INSERT);
	assign can_append = (used_q < kfct_pkg::USED_W'(kfct_pkg::ENTRIES));
	assign hit_inc    = is_insert && (hit_cnt_q != COUNT_MAX);
	assign new_cnt    = hit_inc ? hit_cnt_q + 1'b1 : hit_cnt_q;
	assign do_append  = !hit_q && is_insert && can_append;
	assign full_drop  = !hit_q && is_insert && !can_append;

	always_comb begin
		priority if (hit_q) begin
			occ_raw = new_cnt;
		end else if (do_append) begin
			occ_raw = kfct_pkg::COUNT_BITS'(1);
		end else begin
			occ_raw = '0;
		end
	end

	assign probes_raw = hit_q ? kfct_pkg::USED_W'(hit_pos_q) + 1'b1 : used_q;

	// Counts and probe totals wider than their fields are reported saturated.
	assign occ_ext    = kfct_pkg::OCC_CMP_W'(occ_raw);
	assign occ_out    = (occ_ext > kfct_pkg::OCC_CMP_W'({kfct_pkg::OCC_W{1'b1}}))
	                  ? {kfct_pkg::OCC_W{1'b1}} : occ_ext[kfct_pkg::OCC_W-1:0];
	assign probes_ext = kfct_pkg::PROBE_CMP_W'(probes_raw);
	assign probes_out = (probes_ext > kfct_pkg::PROBE_CMP_W'({kfct_pkg::PROBE_W{1'b1}}))
	                  ? {kfct_pkg::PROBE_W{1'b1}} : probes_ext[kfct_pkg::PROBE_W-1:0];

	// The write-back lands in the closing cycle, so the next search, which
	// reads no earlier than the following cycle, always sees it.
	always_comb begin
		wr.we       = (state_q == ST_FINISH) && out_free && ((hit_q && hit_inc) || do_append);
		wr.addr     = hit_q ? hit_pos_q : used_q[kfct_pkg::IDX_W-1:0];
		wr.data.key = key_q;
		wr.data.cnt = hit_q ? new_cnt : kfct_pkg::COUNT_BITS'(1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			cmd_q     <= kfct_pkg::CMD_INSERT;
			key_q     <= '0;
			used_q    <= '0;
			addr_q    <= '0;
			pos_s1    <= '0;
			hit_q     <= 1'b0;
			hit_pos_q <= '0;
			hit_cnt_q <= '0;
			m_tvalid  <= 1'b0;
			m_tdata   <= '0;
			m_tuser   <= '0;
		end else begin
			// A new result is loaded in the closing cycle whenever the output
			// register is free; otherwise a taken result empties it.
			if ((state_q == ST_FINISH) && out_free) begin
				m_tvalid <= 1'b1;
			end else if (m_tready) begin
				m_tvalid <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (s_xfer) begin
						cmd_q   <= kfct_pkg::cmd_t'(s_tuser);
						key_q   <= s_tdata;
						addr_q  <= kfct_pkg::USED_W'(1);
						pos_s1  <= '0;
						hit_q   <= 1'b0;
						state_q <= (used_q == '0) ? ST_FINISH : ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (addr_q < used_q) begin
						addr_q <= addr_q + 1'b1;
					end
					if (match) begin
						hit_q     <= 1'b1;
						hit_pos_q <= pos_s1;
						hit_cnt_q <= rd_data.cnt;
						state_q   <= ST_FINISH;
					end else if (last_entry) begin
						state_q <= ST_FINISH;
					end else begin
						pos_s1 <= pos_s1 + 1'b1;
					end
				end
				ST_FINISH: begin
					if (out_free) begin
						m_tdata  <= {{kfct_pkg::OUT_PAD_W{1'b0}}, probes_out, occ_out};
						m_tuser  <= {full_drop, hit_q};
						if (do_append) begin
							used_q <= used_q + 1'b1;
						end
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

`include "key_frequency_count_table_assert.svh"

	`KFCT_ASSERT_ALWAYS(a_used_bound, used_q <= kfct_pkg::USED_W'(kfct_pkg::ENTRIES), "fill count beyond table size")
	`KFCT_ASSERT(a_used_step, (used_q == $past(used_q)) || (used_q == $past(used_q) + 1'b1), "fill count moved by more than one")
	`KFCT_ASSERT(a_scan_in_range, (state_q == ST_SCAN) |-> (kfct_pkg::USED_W'(pos_s1) < used_q), "search compared an unused entry")
	`KFCT_ASSERT(a_xfer_starts_work, s_xfer |=> (state_q != ST_IDLE), "accepted request did not start a search")

endmodule

>>> tb/sv/tb.sv
// ----------------------------------------------------------------------------
// Key frequency count table testbench
// Drives insert and lookup requests through the request stream and checks
// every reply against a typed reply or a behavioural model of the table.
// A directed table opens the run. Random traffic follows; it fills the
// table and keeps on inserting, so that new keys are dropped on a full table.
// A stretch of the random traffic runs with no idling on either side.
// ----------------------------------------------------------------------------
module tb;

	import kfct_pkg::*;

	// One reply as the bench sees it, unpacked from the reply stream.
	typedef struct packed {
		logic               found;
		logic [OCC_W-1:0]   occ;
		logic [PROBE_W-1:0] probes;
		logic               full;
	} table_reply_t;

	// One row of the directed plan. Where known is set, the reply is typed
	// in by hand; otherwise the table model supplies it.
	typedef struct packed {
		cmd_t         cmd;
		logic [31:0]  key;
		logic         known;
		table_reply_t reply;
	} plan_row_t;

	localparam int PLAN_ROWS    = 18;
	localparam int RANDOM_ITEMS = 1532;
	localparam int IDLE_PCT     = 23;
	// Random requests in this range are sent with no idling at all.
	localparam int STEADY_FIRST = 500;
	localparam int STEADY_LAST  = 700;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [31:0] s_tdata;   // key[31:0]
	logic        s_tuser;   // cmd
	logic        m_tvalid;
	logic        m_tready;
	logic [31:0] m_tdata;   // occurrences[15:0], probes[24:16], zero pad
	logic [1:0]  m_tuser;   // found, table_full

	key_frequency_count_table dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	// Behavioural copy of the table: keys in arrival order with their counts.
	logic [KEY_W-1:0]      tally_keys   [ENTRIES];
	logic [COUNT_BITS-1:0] tally_counts [ENTRIES];
	int                    tally_used;

	// Replies still owed by the block, oldest first.
	table_reply_t pending_replies [$];
	int           mismatch_count;
	// While set, neither side of the block idles.
	bit           steady_flow;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// This bound lies far beyond the expected length of the run and leaves a
	// wide margin for long stalls on both streams.
	initial begin
		#40_000_000;
		$display("Regression FAIL");
		$finish;
	end

	task automatic note_mismatch(input string what);
		$display("%0t mismatch: %s", $realtime, what);
		mismatch_count++;
	endtask

	// Searches the model table from entry 0 upward, updates it exactly as the
	// block should, and returns the reply that the request must produce.
	function automatic table_reply_t tally_request(input cmd_t cmd,
			input logic [KEY_W-1:0] key);
		table_reply_t     r;
		int               pos;
		bit               hit;
		longint unsigned  occ;
		r   = '0;
		pos = 0;
		hit = 1'b0;
		while (pos < tally_used && !hit) begin
			if (tally_keys[IDX_W'(pos)] == key)
				hit = 1'b1;
			else
				pos++;
		end
		if (hit) begin
			r.found  = 1'b1;
			r.probes = (pos + 1 > 511) ? '1 : PROBE_W'(pos + 1);
			// Counts stick at their top value rather than wrapping.
			if (cmd == CMD_INSERT && tally_counts[IDX_W'(pos)] != '1)
				tally_counts[IDX_W'(pos)] = tally_counts[IDX_W'(pos)] + 1'b1;
			occ   = 64'(tally_counts[IDX_W'(pos)]);
			r.occ = (occ > 64'hFFFF) ? '1 : OCC_W'(occ);
		end else begin
			r.probes = (tally_used > 511) ? '1 : PROBE_W'(tally_used);
			if (cmd == CMD_INSERT) begin
				if (tally_used < ENTRIES) begin
					tally_keys[IDX_W'(tally_used)]   = key;
					tally_counts[IDX_W'(tally_used)] = COUNT_BITS'(1);
					tally_used++;
					r.occ = OCC_W'(1);
				end else begin
					// A new key on a full table is dropped and flagged.
					r.full = 1'b1;
				end
			end
		end
		return r;
	endfunction

	// Offers one request and holds it until the block takes it. The model is
	// updated at the very edge of the transfer, so the next request can be
	// drawn from an up-to-date table.
	task automatic offer_request(input cmd_t cmd, input logic [31:0] key,
			input bit known, input table_reply_t typed_reply);
		table_reply_t modelled;
		while (!steady_flow && $urandom_range(0, 99) < IDLE_PCT) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= key;
		s_tuser  <= cmd;
		do
			@(posedge clk);
		while (!s_tready);
		modelled = tally_request(cmd, key);
		pending_replies.push_back(known ? typed_reply : modelled);
	endtask

	// A key that is new most of the time, but now and then sits one bit away
	// from a stored key or near one of the extremes of the signed key range.
	function automatic logic [31:0] fresh_key();
		int pick;
		pick = $urandom_range(0, 9);
		if (pick < 2 && tally_used > 0)
			return tally_keys[IDX_W'($urandom_range(0, tally_used - 1))]
				^ (32'h1 << $urandom_range(0, 31));
		if (pick == 2)
			return (($urandom_range(0, 1) == 1) ? 32'h8000_0000 : 32'h7FFF_FFFF)
				^ 32'($urandom_range(0, 3));
		return $urandom;
	endfunction

	// Reply side: back-pressure at random and check each reply that is taken
	// against the oldest one owed.
	initial begin
		table_reply_t want;
		table_reply_t got;
		m_tready <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && m_tvalid && m_tready) begin
				got.found  = m_tuser[0];
				got.full   = m_tuser[1];
				got.occ    = m_tdata[15:0];
				got.probes = m_tdata[24:16];
				if (pending_replies.size() == 0) begin
					note_mismatch($sformatf("reply with none owed: %p", got));
				end else begin
					want = pending_replies.pop_front();
					if (got.found !== want.found)
						note_mismatch($sformatf("found %b, expected %b",
							got.found, want.found));
					if (got.occ !== want.occ)
						note_mismatch($sformatf("occurrences %0d, expected %0d",
							got.occ, want.occ));
					if (got.probes !== want.probes)
						note_mismatch($sformatf("probes %0d, expected %0d",
							got.probes, want.probes));
					if (got.full !== want.full)
						note_mismatch($sformatf("table_full %b, expected %b",
							got.full, want.full));
				end
			end
			m_tready <= steady_flow || ($urandom_range(0, 99) >= IDLE_PCT);
		end
	end

	// Request side and run control.
	initial begin
		plan_row_t plan [PLAN_ROWS];
		int        pick;
		cmd_t      cmd;
		logic [31:0] key;

		// Rows with a typed reply check the first few entries by hand: an
		// empty-table lookup, both ends of the signed range, a repeat insert,
		// and a lookup miss that probes every entry in use.
		plan = '{
			'{CMD_LOOKUP, 32'h0000_0000, 1'b1, '{1'b0, 16'd0, 9'd0, 1'b0}},
			'{CMD_INSERT, 32'h8000_0000, 1'b1, '{1'b0, 16'd1, 9'd0, 1'b0}},
			'{CMD_INSERT, 32'h8000_0000, 1'b1, '{1'b1, 16'd2, 9'd1, 1'b0}},
			'{CMD_INSERT, 32'h7FFF_FFFF, 1'b1, '{1'b0, 16'd1, 9'd1, 1'b0}},
			'{CMD_INSERT, 32'hFFFF_FFFF, 1'b1, '{1'b0, 16'd1, 9'd2, 1'b0}},
			'{CMD_INSERT, 32'h0000_0000, 1'b1, '{1'b0, 16'd1, 9'd3, 1'b0}},
			'{CMD_LOOKUP, 32'h7FFF_FFFF, 1'b1, '{1'b1, 16'd1, 9'd2, 1'b0}},
			'{CMD_LOOKUP, 32'h0000_0001, 1'b1, '{1'b0, 16'd0, 9'd4, 1'b0}},
			'{CMD_LOOKUP, 32'h8000_0000, 1'b1, '{1'b1, 16'd2, 9'd1, 1'b0}},
			'{CMD_INSERT, 32'hFFFF_FFFF, 1'b1, '{1'b1, 16'd2, 9'd3, 1'b0}},
			'{CMD_LOOKUP, 32'hFFFF_FFFE, 1'b0, '0},
			'{CMD_INSERT, 32'h7FFF_FFFE, 1'b0, '0},
			'{CMD_INSERT, 32'h0000_0001, 1'b0, '0},
			'{CMD_LOOKUP, 32'h0000_0000, 1'b0, '0},
			'{CMD_INSERT, 32'h5555_5555, 1'b0, '0},
			'{CMD_INSERT, 32'hAAAA_AAAA, 1'b0, '0},
			'{CMD_LOOKUP, 32'hAAAA_AAAA, 1'b0, '0},
			'{CMD_INSERT, 32'h0000_0000, 1'b0, '0}
		};

		tally_used     = 0;
		mismatch_count = 0;
		steady_flow    = 1'b0;
		arst_n   <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata  <= '0;
		s_tuser  <= CMD_INSERT;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[i])
			offer_request(plan[i].cmd, plan[i].key, plan[i].known, plan[i].reply);

		// Random traffic. New keys arrive often enough that the table fills
		// part way through; after that they are dropped with table_full, while
		// repeats and lookups keep probing across the whole table.
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			steady_flow = (n >= STEADY_FIRST) && (n < STEADY_LAST);
			pick = $urandom_range(0, 99);
			if (pick < 40 || tally_used == 0) begin
				cmd = CMD_INSERT;
				key = fresh_key();
			end else if (pick < 70) begin
				cmd = CMD_INSERT;
				key = tally_keys[IDX_W'($urandom_range(0, tally_used - 1))];
			end else if (pick < 90) begin
				cmd = CMD_LOOKUP;
				key = tally_keys[IDX_W'($urandom_range(0, tally_used - 1))];
			end else begin
				cmd = CMD_LOOKUP;
				key = fresh_key();
			end
			offer_request(cmd, key, 1'b0, '0);
		end
		steady_flow = 1'b0;
		s_tvalid <= 1'b0;

		// Drain the replies, then allow one full search more so that any
		// stray reply still shows up before the verdict.
		while (pending_replies.size() != 0)
			@(posedge clk);
		repeat (ENTRIES + 8) @(posedge clk);

		if (mismatch_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

>>> key_frequency_count_table.f
+incdir+hw/rtl
hw/rtl/kfct_pkg.sv
hw/rtl/kfct_store.sv
hw/rtl/key_frequency_count_table.sv
tb/sv/tb.sv
